### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL modules.
// Depends on clk and rst_n being visible in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");

`endif

### hw/rtl/mcfg_pkg.sv
// Types, constants and tables for the MPEG-4 configuration header parser.
// Used by mcfg_queue, mcfg_parser and mpeg4_config_header_parser.
package mcfg_pkg;

  localparam logic [31:0] UD_MARK   = 32'h0000_01B2;
  localparam logic [31:0] VIS_MARK  = 32'h0000_01B5;
  localparam logic [31:0] VO_MAX    = 32'h0000_011F;
  localparam logic [31:0] VOL_MIN   = 32'h0000_0120;
  localparam logic [31:0] VOL_MAX   = 32'h0000_012F;
  localparam logic [23:0] SC_PREFIX = 24'h00_0001;
  localparam logic [3:0]  ASP_EXT   = 4'hF;
  localparam logic [6:0]  VBV_BITS  = 7'd79;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FAIL  = 2'd1;
  localparam logic [1:0] ST_PZERO = 2'd2;

  typedef enum logic [5:0] {
    PH_IDLE, PH_DONE, PH_VOS_HDR,
    PH_VOS_VOSC, PH_VOS_UD1, PH_VIS_ID, PH_VIS_VERID, PH_VIS_TYPE,
    PH_VIS_SIG, PH_VIS_FMT, PH_VIS_COLF, PH_VIS_COL, PH_STUFF0, PH_STUFF1,
    PH_VOS_NEXT, PH_VOS_UD2, PH_VO_SC, PH_VOL_SC, PH_SKIP9, PH_VOL_ID,
    PH_VOL_VERID, PH_ASPECT, PH_PARW, PH_PARH, PH_VOLCTL, PH_CHROMA,
    PH_VBVF, PH_VBV, PH_SHAPE, PH_MK1, PH_RES, PH_MK2, PH_FIXF, PH_FIXINC,
    PH_MK3, PH_WIDTH, PH_MK4, PH_HEIGHT, PH_MK5
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       kind;
  } word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        config_seen;
    logic [7:0]  profile_level;
    logic        aspect_known;
    logic [7:0]  aspect_width;
    logic [7:0]  aspect_height;
    logic [15:0] tick_resolution;
    logic [15:0] fixed_increment;
    logic [12:0] frame_width;
    logic [12:0] frame_height;
  } res_t;

  // Handshake between queue and parser.
  typedef struct packed {
    logic  valid;
    word_t word;
  } qhead_t;

  // Pixel aspect table, codes 1..5.
  function automatic logic [15:0] par_lookup(logic [3:0] code);
    logic [15:0] v;
    case (code)
      4'd1:    v = {8'd1, 8'd1};
      4'd2:    v = {8'd12, 8'd11};
      4'd3:    v = {8'd10, 8'd11};
      4'd4:    v = {8'd16, 8'd11};
      4'd5:    v = {8'd40, 8'd33};
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

### hw/rtl/mpeg4_config_header_parser.sv
// Top level of the MPEG-4 Part 2 VOS/VO/VOL configuration header parser.
// Depends on mcfg_pkg, mcfg_queue and mcfg_parser.
//
//  channel | direction | handshake             | word
//  in_     | input     | in_valid / in_ready   | one packet byte with first/last/kind
//  out_    | output    | out_valid / out_ready | one parse result, on a packet's last byte
//
// All eight bit steps of a byte are settled together by the bit-window logic, so
// a word a cycle is sustained while the result output is not stalled.
// An accepted byte waits in the queue; once the parser pops it, any result is registered.
// Reset (rst_n low, synchronous) empties the queue and returns the parser to idle.
// A stalled result holds in its register; the two-word queue keeps taking bytes
// until it fills, then in_ready drops.
module mpeg4_config_header_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  input  logic        in_last_byte,
  input  logic        in_kind,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_config_seen,
  output logic [7:0]  out_profile_level,
  output logic        out_aspect_known,
  output logic [7:0]  out_aspect_width,
  output logic [7:0]  out_aspect_height,
  output logic [15:0] out_tick_resolution,
  output logic [15:0] out_fixed_increment,
  output logic [12:0] out_frame_width,
  output logic [12:0] out_frame_height
);
  mcfg_pkg::word_t  in_word;
  mcfg_pkg::qhead_t head;
  mcfg_pkg::res_t   res;
  logic             pop;

  // Pack the input word for the queue.
  assign in_word.data  = in_data_byte;
  assign in_word.first = in_first_byte;
  assign in_word.last  = in_last_byte;
  assign in_word.kind  = in_kind;

  mcfg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid && in_ready),
    .push_word (in_word),
    .can_push  (in_ready),
    .pop       (pop),
    .head      (head)
  );

  mcfg_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .res_valid (out_valid),
    .res       (res),
    .res_ready (out_ready)
  );

  // Unpack the result register onto the ports.
  assign out_status          = res.status;
  assign out_config_seen     = res.config_seen;
  assign out_profile_level   = res.profile_level;
  assign out_aspect_known    = res.aspect_known;
  assign out_aspect_width    = res.aspect_width;
  assign out_aspect_height   = res.aspect_height;
  assign out_tick_resolution = res.tick_resolution;
  assign out_fixed_increment = res.fixed_increment;
  assign out_frame_width     = res.frame_width;
  assign out_frame_height    = res.frame_height;
endmodule

### hw/rtl/mcfg_queue.sv
// Front part: two-entry word queue between the input channel and the parser.
// Depends on mcfg_pkg.
`include "assert_macros.svh"
module mcfg_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mcfg_pkg::word_t     push_word,
  output logic                can_push,
  input  logic                pop,
  output mcfg_pkg::qhead_t    head
);
  mcfg_pkg::word_t mem_r [2];
  logic       rd_r, rd_nxt, wr_r, wr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign can_push   = (cnt_r != 2'd2);
  assign head.valid = (cnt_r != 2'd0);
  assign head.word  = mem_r[rd_r];

  always_comb begin
    rd_nxt  = rd_r ^ pop;
    wr_nxt  = wr_r ^ push;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_word;
  end

  `ASSERT_CLK(a_no_overflow, push |-> cnt_r != 2'd2)
  `ASSERT_CLK(a_no_underflow, pop |-> cnt_r != 2'd0)
  `ASSERT_CLK(a_cnt_range, cnt_r != 2'd3)
endmodule

### hw/rtl/mcfg_parser.sv
// Back part: parses one queued word a cycle while the result slot can take a result, and holds the result register.
// Depends on mcfg_pkg.
`include "assert_macros.svh"
module mcfg_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  mcfg_pkg::qhead_t  head,
  output logic              pop,
  output logic              res_valid,
  output mcfg_pkg::res_t    res,
  input  logic              res_ready
);
  typedef struct packed {
    mcfg_pkg::phase_t phase;
    logic [31:0] win;
    logic [6:0]  left;
    logic [2:0]  bidx;
    logic        failed;
    logic [15:0] tick;
    logic [15:0] fixed;
    logic [12:0] width;
    logic [12:0] height;
    logic        aknown;
    logic        seen;
    logic        pzero;
    logic [7:0]  prof;
    logic [7:0]  aw;
    logic [7:0]  ah;
  } pst_t;

  pst_t st_r, st_nxt;
  logic res_valid_r, res_valid_nxt;
  mcfg_pkg::res_t res_r, res_nxt;
  logic emit;

  function automatic pst_t fail_now(pst_t si);
    pst_t s;
    s = si;
    s.failed = 1'b1;
    s.phase  = mcfg_pkg::PH_DONE;
    s.left   = 7'd0;
    return s;
  endfunction

  function automatic pst_t go(pst_t si, mcfg_pkg::phase_t ph, logic [6:0] n);
    pst_t s;
    s = si;
    s.phase = ph;
    s.left  = n;
    return s;
  endfunction

  function automatic pst_t vo_code(pst_t s, logic [31:0] w);
    if (w <= mcfg_pkg::VO_MAX) return go(s, mcfg_pkg::PH_VOL_SC, 7'd32);
    return fail_now(s);
  endfunction

  function automatic pst_t step_bit(pst_t si, logic b, logic aligned);
    pst_t        s;
    logic [31:0] w;
    logic [15:0] r;
    logic [6:0]  n;
    logic [15:0] par;
    s = si;
    s.win = {s.win[30:0], b};
    if (s.left > 7'd1) begin
      s.left = s.left - 7'd1;
      return s;
    end
    s.left = 7'd0;
    w = s.win;
    case (s.phase)
      mcfg_pkg::PH_VOS_VOSC, mcfg_pkg::PH_VOS_UD1: begin
        if (s.phase == mcfg_pkg::PH_VOS_UD1 && w[31:8] != mcfg_pkg::SC_PREFIX)
          s = go(s, mcfg_pkg::PH_VOS_UD1, 7'd8);
        else if (w == mcfg_pkg::UD_MARK) s = go(s, mcfg_pkg::PH_VOS_UD1, 7'd8);
        else if (w == mcfg_pkg::VIS_MARK) s = go(s, mcfg_pkg::PH_VIS_ID, 7'd1);
        else s = fail_now(s);
      end
      mcfg_pkg::PH_VIS_ID:
        s = w[0] ? go(s, mcfg_pkg::PH_VIS_VERID, 7'd7) : go(s, mcfg_pkg::PH_VIS_TYPE, 7'd4);
      mcfg_pkg::PH_VIS_VERID: s = go(s, mcfg_pkg::PH_VIS_TYPE, 7'd4);
      mcfg_pkg::PH_VIS_TYPE:
        s = (w[3:0] != 4'd1) ? fail_now(s) : go(s, mcfg_pkg::PH_VIS_SIG, 7'd1);
      mcfg_pkg::PH_VIS_SIG:
        s = w[0] ? go(s, mcfg_pkg::PH_VIS_FMT, 7'd4) : go(s, mcfg_pkg::PH_STUFF0, 7'd1);
      mcfg_pkg::PH_VIS_FMT: s = go(s, mcfg_pkg::PH_VIS_COLF, 7'd1);
      mcfg_pkg::PH_VIS_COLF:
        s = w[0] ? go(s, mcfg_pkg::PH_VIS_COL, 7'd24) : go(s, mcfg_pkg::PH_STUFF0, 7'd1);
      mcfg_pkg::PH_VIS_COL: s = go(s, mcfg_pkg::PH_STUFF0, 7'd1);
      mcfg_pkg::PH_STUFF0, mcfg_pkg::PH_STUFF1: begin
        if (b != (s.phase == mcfg_pkg::PH_STUFF1)) s = fail_now(s);
        else if (aligned) s = go(s, mcfg_pkg::PH_VOS_NEXT, 7'd32);
        else s = go(s, mcfg_pkg::PH_STUFF1, 7'd1);
      end
      mcfg_pkg::PH_VOS_NEXT:
        s = (w == mcfg_pkg::UD_MARK) ? go(s, mcfg_pkg::PH_VOS_UD2, 7'd8) : vo_code(s, w);
      mcfg_pkg::PH_VOS_UD2:
        s = (w[31:8] != mcfg_pkg::SC_PREFIX || w == mcfg_pkg::UD_MARK)
            ? go(s, mcfg_pkg::PH_VOS_UD2, 7'd8) : vo_code(s, w);
      mcfg_pkg::PH_VO_SC: s = vo_code(s, w);
      mcfg_pkg::PH_VOL_SC:
        s = (w >= mcfg_pkg::VOL_MIN && w <= mcfg_pkg::VOL_MAX)
            ? go(s, mcfg_pkg::PH_SKIP9, 7'd9) : fail_now(s);
      mcfg_pkg::PH_SKIP9: s = go(s, mcfg_pkg::PH_VOL_ID, 7'd1);
      mcfg_pkg::PH_VOL_ID:
        s = w[0] ? go(s, mcfg_pkg::PH_VOL_VERID, 7'd7) : go(s, mcfg_pkg::PH_ASPECT, 7'd4);
      mcfg_pkg::PH_VOL_VERID: s = go(s, mcfg_pkg::PH_ASPECT, 7'd4);
      mcfg_pkg::PH_ASPECT: begin
        if (w[3:0] == 4'd0) s = fail_now(s);
        else if (w[3:0] == mcfg_pkg::ASP_EXT) s = go(s, mcfg_pkg::PH_PARW, 7'd8);
        else begin
          if (w[3:0] <= 4'd5) begin
            par = mcfg_pkg::par_lookup(w[3:0]);
            s.aw = par[15:8];
            s.ah = par[7:0];
            s.aknown = 1'b1;
          end
          s = go(s, mcfg_pkg::PH_VOLCTL, 7'd1);
        end
      end
      mcfg_pkg::PH_PARW: begin
        s.aw = w[7:0];
        s = go(s, mcfg_pkg::PH_PARH, 7'd8);
      end
      mcfg_pkg::PH_PARH: begin
        s.ah = w[7:0];
        s.aknown = 1'b1;
        s = go(s, mcfg_pkg::PH_VOLCTL, 7'd1);
      end
      mcfg_pkg::PH_VOLCTL:
        s = w[0] ? go(s, mcfg_pkg::PH_CHROMA, 7'd3) : go(s, mcfg_pkg::PH_SHAPE, 7'd2);
      mcfg_pkg::PH_CHROMA: s = go(s, mcfg_pkg::PH_VBVF, 7'd1);
      mcfg_pkg::PH_VBVF:
        s = w[0] ? go(s, mcfg_pkg::PH_VBV, mcfg_pkg::VBV_BITS)
                 : go(s, mcfg_pkg::PH_SHAPE, 7'd2);
      mcfg_pkg::PH_VBV: s = go(s, mcfg_pkg::PH_SHAPE, 7'd2);
      mcfg_pkg::PH_SHAPE:
        s = (w[1:0] != 2'd0) ? fail_now(s) : go(s, mcfg_pkg::PH_MK1, 7'd1);
      mcfg_pkg::PH_MK1: s = w[0] ? go(s, mcfg_pkg::PH_RES, 7'd16) : fail_now(s);
      mcfg_pkg::PH_MK2: s = w[0] ? go(s, mcfg_pkg::PH_FIXF, 7'd1) : fail_now(s);
      mcfg_pkg::PH_MK3: s = w[0] ? go(s, mcfg_pkg::PH_WIDTH, 7'd13) : fail_now(s);
      mcfg_pkg::PH_MK4: s = w[0] ? go(s, mcfg_pkg::PH_HEIGHT, 7'd13) : fail_now(s);
      mcfg_pkg::PH_MK5: begin
        if (!w[0]) s = fail_now(s);
        else begin
          s.seen = 1'b1;
          s = go(s, mcfg_pkg::PH_DONE, 7'd0);
        end
      end
      mcfg_pkg::PH_RES: begin
        s.tick = w[15:0];
        s = go(s, mcfg_pkg::PH_MK2, 7'd1);
      end
      mcfg_pkg::PH_FIXF: begin
        if (w[0]) begin
          r = s.tick - 16'd1;
          n = 7'd0;
          for (int i = 0; i < 16; i++) begin
            if (r[i]) n = 7'(i + 1);
          end
          if (n == 7'd0) n = 7'd1;
          s = go(s, mcfg_pkg::PH_FIXINC, n);
        end else begin
          s = go(s, mcfg_pkg::PH_MK3, 7'd1);
        end
      end
      mcfg_pkg::PH_FIXINC: begin
        s.fixed = w[15:0];
        s = go(s, mcfg_pkg::PH_MK3, 7'd1);
      end
      mcfg_pkg::PH_WIDTH: begin
        s.width = w[12:0];
        s = go(s, mcfg_pkg::PH_MK4, 7'd1);
      end
      mcfg_pkg::PH_HEIGHT: begin
        s.height = w[12:0];
        s = go(s, mcfg_pkg::PH_MK5, 7'd1);
      end
      default: s = fail_now(s);
    endcase
    return s;
  endfunction

  // Take the head word whenever the result slot can accept a new result.
  assign pop       = head.valid && (!res_valid_r || res_ready);
  assign res_valid = res_valid_r;
  assign res       = res_r;

  always_comb begin
    pst_t s;
    s = st_r;
    emit = 1'b0;
    res_nxt = res_r;
    if (head.word.first) begin
      s.tick = 16'd0; s.fixed = 16'd0; s.width = 13'd0; s.height = 13'd0;
      s.aknown = 1'b0; s.seen = 1'b0; s.pzero = 1'b0;
      s.prof = 8'd0; s.aw = 8'd0; s.ah = 8'd0;
      s.failed = 1'b0;
      s.win = 32'd0;
      s.bidx = 3'd0;
      s = head.word.kind ? go(s, mcfg_pkg::PH_VO_SC, 7'd32)
                         : go(s, mcfg_pkg::PH_VOS_HDR, 7'd0);
    end
    if (s.phase != mcfg_pkg::PH_IDLE) begin
      if (s.phase == mcfg_pkg::PH_VOS_HDR) begin
        if (s.bidx < 3'd4) s.bidx = s.bidx + 3'd1;
        else if (head.word.data == 8'd0) begin
          s.pzero = 1'b1;
          s = fail_now(s);
        end else begin
          s.prof = head.word.data;
          s.seen = 1'b1;
          s = go(s, mcfg_pkg::PH_VOS_VOSC, 7'd32);
        end
      end else begin
        for (int i = 7; i >= 0; i--) begin
          if (s.phase != mcfg_pkg::PH_DONE)
            s = step_bit(s, head.word.data[i], i == 0);
        end
      end
      if (head.word.last) begin
        emit = 1'b1;
        if (s.pzero) res_nxt.status = mcfg_pkg::ST_PZERO;
        else if (s.phase == mcfg_pkg::PH_DONE && !s.failed) res_nxt.status = mcfg_pkg::ST_OK;
        else res_nxt.status = mcfg_pkg::ST_FAIL;
        res_nxt.config_seen     = s.seen;
        res_nxt.profile_level   = s.prof;
        res_nxt.aspect_known    = s.aknown;
        res_nxt.aspect_width    = s.aknown ? s.aw : 8'd0;
        res_nxt.aspect_height   = s.aknown ? s.ah : 8'd0;
        res_nxt.tick_resolution = s.tick;
        res_nxt.fixed_increment = s.fixed;
        res_nxt.frame_width     = s.width;
        res_nxt.frame_height    = s.height;
        s = go(s, mcfg_pkg::PH_IDLE, 7'd0);
      end
    end
    st_nxt = pop ? s : st_r;
    if (pop) res_valid_nxt = emit;
    else res_valid_nxt = res_valid_r && !res_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      res_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) res_r <= res_nxt;
  end

  `ASSERT_CLK(a_res_held, res_valid_r && !res_ready |=> res_valid_r && $stable(res_r))
  `ASSERT_CLK(a_pop_slot, pop |-> !res_valid_r || res_ready)
  `ASSERT_CLK(a_idle_no_left, st_r.phase == mcfg_pkg::PH_IDLE |-> st_r.left == 7'd0)
endmodule

### bench/tb.sv
// Self-checking bench for mpeg4_config_header_parser: random and directed
// configuration packets, predicted results compared word by word.
// Depends on mcfg_pkg and the parser RTL.
`timescale 1ns / 1ps

module tb;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  logic [7:0]      in_data_byte;
  logic            in_first_byte;
  logic            in_last_byte;
  logic            in_kind;
  logic            out_valid;
  logic            out_ready;
  mcfg_pkg::res_t  got;

  mpeg4_config_header_parser dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_first_byte      (in_first_byte),
    .in_last_byte       (in_last_byte),
    .in_kind            (in_kind),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (got.status),
    .out_config_seen    (got.config_seen),
    .out_profile_level  (got.profile_level),
    .out_aspect_known   (got.aspect_known),
    .out_aspect_width   (got.aspect_width),
    .out_aspect_height  (got.aspect_height),
    .out_tick_resolution(got.tick_resolution),
    .out_fixed_increment(got.fixed_increment),
    .out_frame_width    (got.frame_width),
    .out_frame_height   (got.frame_height)
  );

  // 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Header predictor: its own copy of the parse state, advanced once per
  // accepted word.
  // ---------------------------------------------------------------------------
  mcfg_pkg::phase_t hdr_phase;
  logic [31:0]      hdr_window;
  int               hdr_left;
  int               hdr_hdr_count;
  bit               hdr_failed;
  bit               hdr_pzero;
  mcfg_pkg::res_t   hdr_fields;

  function automatic void hdr_go(mcfg_pkg::phase_t ph, int n);
    hdr_phase = ph;
    hdr_left  = n;
  endfunction

  function automatic void hdr_fail();
    hdr_failed = 1'b1;
    hdr_phase  = mcfg_pkg::PH_DONE;
    hdr_left   = 0;
  endfunction

  function automatic void hdr_vo_code(logic [31:0] w);
    if (w <= mcfg_pkg::VO_MAX) hdr_go(mcfg_pkg::PH_VOL_SC, 32);
    else hdr_fail();
  endfunction

  // Shift one bit into the window; act once the current field is complete.
  function automatic void hdr_bit(logic b, bit aligned);
    logic [31:0] w;
    logic [15:0] r;
    int          n;
    hdr_window = {hdr_window[30:0], b};
    if (hdr_left > 1) begin
      hdr_left--;
      return;
    end
    hdr_left = 0;
    w = hdr_window;
    case (hdr_phase)
      mcfg_pkg::PH_VOS_VOSC, mcfg_pkg::PH_VOS_UD1: begin
        if (hdr_phase == mcfg_pkg::PH_VOS_UD1 && w[31:8] != mcfg_pkg::SC_PREFIX)
          hdr_go(mcfg_pkg::PH_VOS_UD1, 8);
        else if (w == mcfg_pkg::UD_MARK) hdr_go(mcfg_pkg::PH_VOS_UD1, 8);
        else if (w == mcfg_pkg::VIS_MARK) hdr_go(mcfg_pkg::PH_VIS_ID, 1);
        else hdr_fail();
      end
      mcfg_pkg::PH_VIS_ID: begin
        if (w[0]) hdr_go(mcfg_pkg::PH_VIS_VERID, 7);
        else hdr_go(mcfg_pkg::PH_VIS_TYPE, 4);
      end
      mcfg_pkg::PH_VIS_VERID: hdr_go(mcfg_pkg::PH_VIS_TYPE, 4);
      mcfg_pkg::PH_VIS_TYPE: begin
        if (w[3:0] != 4'd1) hdr_fail();
        else hdr_go(mcfg_pkg::PH_VIS_SIG, 1);
      end
      mcfg_pkg::PH_VIS_SIG: begin
        if (w[0]) hdr_go(mcfg_pkg::PH_VIS_FMT, 4);
        else hdr_go(mcfg_pkg::PH_STUFF0, 1);
      end
      mcfg_pkg::PH_VIS_FMT: hdr_go(mcfg_pkg::PH_VIS_COLF, 1);
      mcfg_pkg::PH_VIS_COLF: begin
        if (w[0]) hdr_go(mcfg_pkg::PH_VIS_COL, 24);
        else hdr_go(mcfg_pkg::PH_STUFF0, 1);
      end
      mcfg_pkg::PH_VIS_COL: hdr_go(mcfg_pkg::PH_STUFF0, 1);
      mcfg_pkg::PH_STUFF0, mcfg_pkg::PH_STUFF1: begin
        if (b != (hdr_phase == mcfg_pkg::PH_STUFF1)) hdr_fail();
        else if (aligned) hdr_go(mcfg_pkg::PH_VOS_NEXT, 32);
        else hdr_go(mcfg_pkg::PH_STUFF1, 1);
      end
      mcfg_pkg::PH_VOS_NEXT: begin
        if (w == mcfg_pkg::UD_MARK) hdr_go(mcfg_pkg::PH_VOS_UD2, 8);
        else hdr_vo_code(w);
      end
      mcfg_pkg::PH_VOS_UD2: begin
        if (w[31:8] != mcfg_pkg::SC_PREFIX || w == mcfg_pkg::UD_MARK)
          hdr_go(mcfg_pkg::PH_VOS_UD2, 8);
        else hdr_vo_code(w);
      end
      mcfg_pkg::PH_VO_SC: hdr_vo_code(w);
      mcfg_pkg::PH_VOL_SC: begin
        if (w >= mcfg_pkg::VOL_MIN && w <= mcfg_pkg::VOL_MAX) hdr_go(mcfg_pkg::PH_SKIP9, 9);
        else hdr_fail();
      end
      mcfg_pkg::PH_SKIP9: hdr_go(mcfg_pkg::PH_VOL_ID, 1);
      mcfg_pkg::PH_VOL_ID: begin
        if (w[0]) hdr_go(mcfg_pkg::PH_VOL_VERID, 7);
        else hdr_go(mcfg_pkg::PH_ASPECT, 4);
      end
      mcfg_pkg::PH_VOL_VERID: hdr_go(mcfg_pkg::PH_ASPECT, 4);
      mcfg_pkg::PH_ASPECT: begin
        if (w[3:0] == 4'd0) hdr_fail();
        else if (w[3:0] == mcfg_pkg::ASP_EXT) hdr_go(mcfg_pkg::PH_PARW, 8);
        else begin
          // Table codes; reserved codes leave the ratio unknown.
          case (w[3:0])
            4'd1: {hdr_fields.aspect_width, hdr_fields.aspect_height} = {8'd1, 8'd1};
            4'd2: {hdr_fields.aspect_width, hdr_fields.aspect_height} = {8'd12, 8'd11};
            4'd3: {hdr_fields.aspect_width, hdr_fields.aspect_height} = {8'd10, 8'd11};
            4'd4: {hdr_fields.aspect_width, hdr_fields.aspect_height} = {8'd16, 8'd11};
            4'd5: {hdr_fields.aspect_width, hdr_fields.aspect_height} = {8'd40, 8'd33};
            default: ;
          endcase
          if (w[3:0] <= 4'd5) hdr_fields.aspect_known = 1'b1;
          hdr_go(mcfg_pkg::PH_VOLCTL, 1);
        end
      end
      mcfg_pkg::PH_PARW: begin
        hdr_fields.aspect_width = w[7:0];
        hdr_go(mcfg_pkg::PH_PARH, 8);
      end
      mcfg_pkg::PH_PARH: begin
        hdr_fields.aspect_height = w[7:0];
        hdr_fields.aspect_known  = 1'b1;
        hdr_go(mcfg_pkg::PH_VOLCTL, 1);
      end
      mcfg_pkg::PH_VOLCTL: begin
        if (w[0]) hdr_go(mcfg_pkg::PH_CHROMA, 3);
        else hdr_go(mcfg_pkg::PH_SHAPE, 2);
      end
      mcfg_pkg::PH_CHROMA: hdr_go(mcfg_pkg::PH_VBVF, 1);
      mcfg_pkg::PH_VBVF: begin
        if (w[0]) hdr_go(mcfg_pkg::PH_VBV, int'(mcfg_pkg::VBV_BITS));
        else hdr_go(mcfg_pkg::PH_SHAPE, 2);
      end
      mcfg_pkg::PH_VBV: hdr_go(mcfg_pkg::PH_SHAPE, 2);
      mcfg_pkg::PH_SHAPE: begin
        if (w[1:0] != 2'd0) hdr_fail();
        else hdr_go(mcfg_pkg::PH_MK1, 1);
      end
      mcfg_pkg::PH_MK1, mcfg_pkg::PH_MK2, mcfg_pkg::PH_MK3, mcfg_pkg::PH_MK4,
      mcfg_pkg::PH_MK5: begin
        if (!w[0]) hdr_fail();
        else if (hdr_phase == mcfg_pkg::PH_MK1) hdr_go(mcfg_pkg::PH_RES, 16);
        else if (hdr_phase == mcfg_pkg::PH_MK2) hdr_go(mcfg_pkg::PH_FIXF, 1);
        else if (hdr_phase == mcfg_pkg::PH_MK3) hdr_go(mcfg_pkg::PH_WIDTH, 13);
        else if (hdr_phase == mcfg_pkg::PH_MK4) hdr_go(mcfg_pkg::PH_HEIGHT, 13);
        else begin
          hdr_fields.config_seen = 1'b1;
          hdr_go(mcfg_pkg::PH_DONE, 0);
        end
      end
      mcfg_pkg::PH_RES: begin
        hdr_fields.tick_resolution = w[15:0];
        hdr_go(mcfg_pkg::PH_MK2, 1);
      end
      mcfg_pkg::PH_FIXF: begin
        if (w[0]) begin
          // Field width is the bit count of resolution - 1, at least one.
          r = hdr_fields.tick_resolution - 16'd1;
          n = 0;
          while (n < 16 && (r >> n) != 0) n++;
          if (n == 0) n = 1;
          hdr_go(mcfg_pkg::PH_FIXINC, n);
        end else begin
          hdr_go(mcfg_pkg::PH_MK3, 1);
        end
      end
      mcfg_pkg::PH_FIXINC: begin
        hdr_fields.fixed_increment = w[15:0];
        hdr_go(mcfg_pkg::PH_MK3, 1);
      end
      mcfg_pkg::PH_WIDTH: begin
        hdr_fields.frame_width = w[12:0];
        hdr_go(mcfg_pkg::PH_MK4, 1);
      end
      mcfg_pkg::PH_HEIGHT: begin
        hdr_fields.frame_height = w[12:0];
        hdr_go(mcfg_pkg::PH_MK5, 1);
      end
      default: hdr_fail();
    endcase
  endfunction

  // Advance the predictor by one word; has_res tells whether a result follows.
  function automatic void hdr_predict(logic [7:0] d, logic f, logic l, logic k,
                                      output bit has_res, output mcfg_pkg::res_t res);
    has_res = 1'b0;
    res     = '0;
    if (f) begin
      hdr_fields    = '0;
      hdr_pzero     = 1'b0;
      hdr_failed    = 1'b0;
      hdr_window    = '0;
      hdr_hdr_count = 0;
      if (k) hdr_go(mcfg_pkg::PH_VO_SC, 32);
      else hdr_go(mcfg_pkg::PH_VOS_HDR, 0);
    end
    if (hdr_phase == mcfg_pkg::PH_IDLE) return;
    if (hdr_phase == mcfg_pkg::PH_VOS_HDR) begin
      if (hdr_hdr_count < 4) hdr_hdr_count++;
      else if (d == 8'd0) begin
        hdr_pzero = 1'b1;
        hdr_fail();
      end else begin
        hdr_fields.profile_level = d;
        hdr_fields.config_seen   = 1'b1;
        hdr_go(mcfg_pkg::PH_VOS_VOSC, 32);
      end
    end else begin
      for (int i = 7; i >= 0 && hdr_phase != mcfg_pkg::PH_DONE; i--) hdr_bit(d[i], i == 0);
    end
    if (!l) return;
    has_res = 1'b1;
    res = hdr_fields;
    if (hdr_pzero) res.status = mcfg_pkg::ST_PZERO;
    else if (hdr_phase == mcfg_pkg::PH_DONE && !hdr_failed) res.status = mcfg_pkg::ST_OK;
    else res.status = mcfg_pkg::ST_FAIL;
    if (!res.aspect_known) begin
      res.aspect_width  = '0;
      res.aspect_height = '0;
    end
    hdr_phase = mcfg_pkg::PH_IDLE;
    hdr_left  = 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Expected results and checking.
  // ---------------------------------------------------------------------------
  mcfg_pkg::res_t expected_res[$];
  int   mismatches;
  int   results_seen;
  int   status_count[4];
  bit   quiet;        // no idling on either side in the last part of the run
  bit   hold_start;
  bit   hold_done;
  int   idle_cycles;

  // Compare every result word with the oldest expectation.
  always @(posedge clk) begin
    mcfg_pkg::res_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      status_count[got.status]++;
      if (results_seen == 20) hold_start = 1'b1;
      if (expected_res.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word: %p", got);
      end else begin
        want = expected_res.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch:\n  exp %p\n  got %p", want, got);
        end
      end
    end
  end

  // Watchdog: too long with no word moving on either channel ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= 3000) begin
        $display("timeout: no word moved for %0d cycles", idle_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Result side: random stall bursts, and one long hold-off so the input
  // queue fills and in_ready drops.
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_start && !hold_done) begin
        out_ready = 1'b0;
        repeat (300) @(negedge clk);
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(0, 2)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [7:0]     data;
    logic           first;
    logic           last;
    logic           kind;
    bit             typed;
    mcfg_pkg::res_t want;
  } row_t;

  row_t directed_rows[$];
  bit   bitq[$];
  int   words_sent;
  int   packets_sent;

  function automatic mcfg_pkg::res_t mk_res(logic [1:0] st, logic seen, logic [7:0] prof);
    mcfg_pkg::res_t r;
    r = '0;
    r.status        = st;
    r.config_seen   = seen;
    r.profile_level = prof;
    return r;
  endfunction

  function automatic void add_row(logic [7:0] d, logic f, logic l, logic k,
                                  bit typed, mcfg_pkg::res_t want);
    row_t r;
    r.data  = d;
    r.first = f;
    r.last  = l;
    r.kind  = k;
    r.typed = typed;
    r.want  = want;
    directed_rows.push_back(r);
  endfunction

  // Offer one word at a falling edge, after an occasional random pause, hold it
  // until accepted, then step the predictor. Returns at the following falling edge.
  task automatic send_word(logic [7:0] d, logic f, logic l, logic k,
                           bit typed, mcfg_pkg::res_t want);
    bit             has_res;
    mcfg_pkg::res_t res;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_data_byte  = d;
    in_first_byte = f;
    in_last_byte  = l;
    in_kind       = k;
    in_valid      = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    hdr_predict(d, f, l, k, has_res, res);
    if (has_res) expected_res.push_back(typed ? want : res);
    if (hdr_phase != mcfg_pkg::PH_IDLE || has_res) words_sent++;
    @(negedge clk);
  endtask

  // Append n bits of v, MSB first.
  function automatic void put_bits(logic [31:0] v, int n);
    for (int i = n - 1; i >= 0; i--) bitq.push_back(v[i]);
  endfunction

  function automatic void put_marker();
    put_bits({31'd0, $urandom_range(0, 24) != 0}, 1);
  endfunction

  // Build one packet as bits: mostly well formed, with random content and
  // occasional bad codes, markers and shapes.
  function automatic void build_packet(logic k);
    logic [15:0] res16;
    logic [15:0] rm1;
    logic [3:0]  asp;
    int          n;
    bitq.delete();
    if (!k) begin
      put_bits(32'h0000_01B0, 32);
      put_bits(($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 255), 8);
      if ($urandom_range(0, 3) == 0) begin
        put_bits(mcfg_pkg::UD_MARK, 32);
        repeat ($urandom_range(1, 3)) put_bits($urandom_range(0, 255), 8);
      end
      put_bits(($urandom_range(0, 20) == 0) ? $urandom() : mcfg_pkg::VIS_MARK, 32);
      if ($urandom_range(0, 1)) begin
        put_bits(1, 1);
        put_bits($urandom_range(0, 127), 7);
      end else begin
        put_bits(0, 1);
      end
      put_bits(($urandom_range(0, 15) == 0) ? $urandom_range(0, 15) : 1, 4);
      if ($urandom_range(0, 1)) begin
        put_bits(1, 1);
        put_bits($urandom_range(0, 15), 4);
        if ($urandom_range(0, 1)) begin
          put_bits(1, 1);
          put_bits($urandom(), 24);
        end else begin
          put_bits(0, 1);
        end
      end else begin
        put_bits(0, 1);
      end
      // Stuffing: a zero, then ones up to the byte boundary, with the odd wrong bit.
      put_bits({31'd0, $urandom_range(0, 20) == 0}, 1);
      while (bitq.size() % 8 != 0) put_bits({31'd0, $urandom_range(0, 30) != 0}, 1);
      if ($urandom_range(0, 3) == 0) begin
        put_bits(mcfg_pkg::UD_MARK, 32);
        repeat ($urandom_range(1, 3)) put_bits($urandom_range(1, 255), 8);
      end
    end
    put_bits(($urandom_range(0, 20) == 0) ? $urandom() :
             32'h0000_0100 + $urandom_range(0, 31), 32);
    put_bits(($urandom_range(0, 20) == 0) ? $urandom() :
             32'h0000_0120 + $urandom_range(0, 15), 32);
    put_bits($urandom_range(0, 511), 9);
    if ($urandom_range(0, 1)) begin
      put_bits(1, 1);
      put_bits($urandom_range(0, 127), 7);
    end else begin
      put_bits(0, 1);
    end
    case ($urandom_range(0, 9))
      0:       asp = 4'd0;
      1:       asp = 4'($urandom_range(6, 14));
      2, 3:    asp = mcfg_pkg::ASP_EXT;
      default: asp = 4'($urandom_range(1, 5));
    endcase
    put_bits({28'd0, asp}, 4);
    if (asp == mcfg_pkg::ASP_EXT) put_bits($urandom_range(0, 65535), 16);
    if ($urandom_range(0, 1)) begin
      put_bits(1, 1);
      put_bits($urandom_range(0, 7), 3);
      if ($urandom_range(0, 1)) begin
        put_bits(1, 1);
        put_bits($urandom(), 32);
        put_bits($urandom(), 32);
        put_bits($urandom(), 15);
      end else begin
        put_bits(0, 1);
      end
    end else begin
      put_bits(0, 1);
    end
    put_bits(($urandom_range(0, 20) == 0) ? $urandom_range(1, 3) : 0, 2);
    put_marker();
    case ($urandom_range(0, 7))
      0:       res16 = 16'd0;
      1:       res16 = 16'd1;
      2:       res16 = 16'hFFFF;
      3:       res16 = 16'd2;
      default: res16 = 16'($urandom_range(0, 65535));
    endcase
    put_bits({16'd0, res16}, 16);
    put_marker();
    if ($urandom_range(0, 1)) begin
      rm1 = res16 - 16'd1;
      n = 1;
      while (n < 16 && (rm1 >> n) != 0) n++;
      put_bits(1, 1);
      put_bits($urandom(), n);
    end else begin
      put_bits(0, 1);
    end
    put_marker();
    put_bits(($urandom_range(0, 5) == 0) ? 32'h1FFF : $urandom_range(0, 8191), 13);
    put_marker();
    put_bits(($urandom_range(0, 5) == 0) ? 32'h0000 : $urandom_range(0, 8191), 13);
    put_marker();
    while (bitq.size() % 8 != 0) put_bits($urandom_range(0, 1), 1);
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 2)) put_bits($urandom(), 8);
    // Corrupt one bit now and then.
    if ($urandom_range(0, 5) == 0) begin
      n = $urandom_range(0, bitq.size() - 1);
      bitq[n] = !bitq[n];
    end
  endfunction

  // Send the built packet; sometimes cut it short or drop its last mark so
  // the next packet restarts the parse.
  task automatic send_packet(logic k);
    int   nbytes;
    bit   no_last;
    logic [7:0] b;
    nbytes = bitq.size() / 8;
    if ($urandom_range(0, 9) == 0) nbytes = $urandom_range(1, nbytes);
    no_last = ($urandom_range(0, 11) == 0);
    for (int i = 0; i < nbytes; i++) begin
      for (int j = 0; j < 8; j++) b[7 - j] = bitq[i * 8 + j];
      send_word(b, i == 0, (i == nbytes - 1) && !no_last, k, 1'b0, '0);
    end
    packets_sent++;
  endtask

  initial begin
    logic k;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data_byte  = '0;
    in_first_byte = 1'b0;
    in_last_byte  = 1'b0;
    in_kind       = 1'b0;
    hdr_phase     = mcfg_pkg::PH_IDLE;
    hdr_window    = '0;
    hdr_left      = 0;
    hdr_hdr_count = 0;
    hdr_failed    = 1'b0;
    hdr_pzero     = 1'b0;
    hdr_fields    = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Stray word while idle: ignored, no result even with last set.
    add_row(8'hAA, 1'b0, 1'b1, 1'b0, 1'b0, '0);
    // VOS packet that ends right after the start code: no profile parsed.
    add_row(8'h00, 1'b1, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h01, 1'b0, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'hB0, 1'b0, 1'b1, 1'b0, 1'b1, mk_res(mcfg_pkg::ST_FAIL, 1'b0, 8'h00));
    // Profile zero.
    add_row(8'h00, 1'b1, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h01, 1'b0, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'hB0, 1'b0, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b1, 1'b0, 1'b1, mk_res(mcfg_pkg::ST_PZERO, 1'b0, 8'h00));
    // VO packet of one byte: data ran out.
    add_row(8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, mk_res(mcfg_pkg::ST_FAIL, 1'b0, 8'h00));
    // Largest profile, then the packet ends before the visual object header.
    add_row(8'h00, 1'b1, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h01, 1'b0, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'hB0, 1'b0, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'hB5, 1'b0, 1'b1, 1'b0, 1'b1, mk_res(mcfg_pkg::ST_FAIL, 1'b1, 8'hFF));
    // New first word inside a packet restarts the parse.
    add_row(8'h00, 1'b1, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b1, 1'b0, 1'b1, 1'b0, '0);
    add_row(8'h01, 1'b0, 1'b1, 1'b0, 1'b0, '0);
    add_row(8'h55, 1'b0, 1'b0, 1'b1, 1'b0, '0);
    foreach (directed_rows[i])
      send_word(directed_rows[i].data, directed_rows[i].first, directed_rows[i].last,
                directed_rows[i].kind, directed_rows[i].typed, directed_rows[i].want);

    // Random packets until the word budget is spent.
    while (words_sent < 1550) begin
      if (words_sent > 1300) quiet = 1'b1;
      // Pause the sender once until every expected result has drained.
      if (packets_sent == 30) begin
        in_valid = 1'b0;
        while (expected_res.size() != 0) @(negedge clk);
      end
      // Noise between packets: stray words without a first mark, ignored while the parser is idle.
      if ($urandom_range(0, 7) == 0)
        repeat ($urandom_range(1, 3))
          send_word(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 1'b0, '0);
      k = 1'($urandom_range(0, 1));
      build_packet(k);
      send_packet(k);
    end
    in_valid = 1'b0;

    // Drain, then allow for the pipeline latency.
    while (expected_res.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d packets, %0d words, %0d results (ok %0d, fail %0d, profile zero %0d)",
             packets_sent, words_sent, results_seen, status_count[mcfg_pkg::ST_OK],
             status_count[mcfg_pkg::ST_FAIL], status_count[mcfg_pkg::ST_PZERO]);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
